### design/p12tk_pkg.sv
// Shared types and constants for the packed 12-bit top-k and recent log.
// Used by the cell modules and the top level; depends on nothing.
package p12tk_pkg;

   localparam int VALUE_BITS = 12;
   localparam int BYTE_BITS  = 8;
   localparam int NIB_BITS   = 4;

   typedef logic [VALUE_BITS-1:0] value_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_PUSH,
      CMD_POP
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    full;
   } chain_ctl_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_THIRD
   } phase_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   typedef enum logic {
      OP_DATA,
      OP_REPORT
   } op_type;

endpackage

### design/p12tk_top_cell.sv
// One cell of the ascending sorted chain that keeps the largest values.
// Depends on p12tk_pkg; talks to its two neighbors every cycle.
module p12tk_top_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  p12tk_pkg::chain_ctl_type ctl,
   input  p12tk_pkg::value_type  new_value,
   input  logic                  lo_le,
   input  p12tk_pkg::value_type  lo_value,
   input  logic                  lo_valid,
   input  logic                  hi_le,
   input  p12tk_pkg::value_type  hi_value,
   input  logic                  hi_valid,
   output p12tk_pkg::value_type  value,
   output logic                  valid,
   output logic                  le
);

   p12tk_pkg::value_type value_ff;
   p12tk_pkg::value_type value_in;
   logic                 valid_ff;
   logic                 valid_in;

   assign le    = valid_ff && (value_ff <= new_value);
   assign value = value_ff;
   assign valid = valid_ff;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (ctl.cmd)
         p12tk_pkg::CMD_PUSH: begin
            if (!ctl.full) begin
               if (!le) begin
                  if (!lo_le) begin
                     value_in = lo_value;
                     valid_in = lo_valid;
                  end else begin
                     value_in = new_value;
                     valid_in = 1'b1;
                  end
               end
            end else if (le) begin
               value_in = hi_le ? hi_value : new_value;
            end
         end
         p12tk_pkg::CMD_POP: begin
            value_in = hi_value;
            valid_in = hi_valid;
         end
         default: begin
            value_in = value_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### design/p12tk_rec_cell.sv
// One cell of the recent-value chain, oldest value in the lowest cell.
// Depends on p12tk_pkg; talks to its two neighbors every cycle.
module p12tk_rec_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  p12tk_pkg::chain_ctl_type ctl,
   input  p12tk_pkg::value_type  new_value,
   input  logic                  is_last,
   input  logic                  lo_valid,
   input  p12tk_pkg::value_type  hi_value,
   input  logic                  hi_valid,
   output p12tk_pkg::value_type  value,
   output logic                  valid
);

   p12tk_pkg::value_type value_ff;
   p12tk_pkg::value_type value_in;
   logic                 valid_ff;
   logic                 valid_in;

   assign value = value_ff;
   assign valid = valid_ff;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (ctl.cmd)
         p12tk_pkg::CMD_PUSH: begin
            if (ctl.full) begin
               value_in = is_last ? new_value : hi_value;
            end else if (!valid_ff && lo_valid) begin
               value_in = new_value;
               valid_in = 1'b1;
            end
         end
         p12tk_pkg::CMD_POP: begin
            value_in = hi_value;
            valid_in = hi_valid;
         end
         default: begin
            value_in = value_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### design/packed12_top_k_and_recent_log.sv
// Packed 12-bit unpacker with a sorted top-k chain and a recent-value chain.
// Data transfers: one byte per cycle when idle; both chains take each unpacked value at once.
// Report: once the report transfer enters drain, registered results follow one per cycle
// (rsp_tready permitting); input stalls until the chains are drained, one cell shift a result.
// Reset (synchronous, active high) empties both chains and restarts the unpack phase.
// Depends on p12tk_pkg, p12tk_top_cell and p12tk_rec_cell.
module packed12_top_k_and_recent_log #(
   parameter int TOP_COUNT    = 32,
   parameter int RECENT_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] value, [15:12] zero
   output logic        rsp_tuser,   // [0] section
   output logic        rsp_tlast    // last_of_run
);

   p12tk_pkg::state_type state_ff;
   p12tk_pkg::state_type state_in;
   p12tk_pkg::phase_type phase_ff;
   p12tk_pkg::phase_type phase_in;
   logic [p12tk_pkg::BYTE_BITS-1:0] held_ff;
   logic [p12tk_pkg::BYTE_BITS-1:0] held_in;

   logic                 req_xfer;
   logic                 push_en;
   p12tk_pkg::value_type push_value;
   logic                 load;
   logic                 any_left;
   logic                 last_now;

   p12tk_pkg::chain_ctl_type top_ctl;
   p12tk_pkg::chain_ctl_type rec_ctl;

   p12tk_pkg::value_type top_val [TOP_COUNT];
   logic [TOP_COUNT-1:0] top_vld;
   logic [TOP_COUNT-1:0] top_le;
   p12tk_pkg::value_type rec_val [RECENT_COUNT];
   logic [RECENT_COUNT-1:0] rec_vld;
   logic [TOP_COUNT-1:0]    top_vld_up;
   logic [RECENT_COUNT-1:0] rec_vld_up;

   logic                 rsp_tvalid_ff;
   logic                 rsp_tvalid_in;
   p12tk_pkg::value_type rsp_value_ff;
   logic                 rsp_section_ff;
   logic                 rsp_last_ff;

   assign req_tready = (state_ff == p12tk_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      push_en    = 1'b0;
      push_value = {held_ff, req_tdata[7:4]};
      if (req_xfer) begin
         if (req_tuser == p12tk_pkg::OP_REPORT) begin
            phase_in = p12tk_pkg::PH_FIRST;
            held_in  = '0;
         end else begin
            case (phase_ff)
               p12tk_pkg::PH_SECOND: begin
                  push_en    = 1'b1;
                  push_value = {held_ff, req_tdata[7:4]};
                  held_in    = req_tdata;
                  phase_in   = p12tk_pkg::PH_THIRD;
               end
               p12tk_pkg::PH_THIRD: begin
                  push_en    = 1'b1;
                  push_value = {held_ff[p12tk_pkg::NIB_BITS-1:0], req_tdata};
                  phase_in   = p12tk_pkg::PH_FIRST;
               end
               default: begin
                  held_in  = req_tdata;
                  phase_in = p12tk_pkg::PH_SECOND;
               end
            endcase
         end
      end
   end

   // drain side
   assign top_vld_up = top_vld >> 1;
   assign rec_vld_up = rec_vld >> 1;
   assign any_left   = top_vld[0] || rec_vld[0];
   assign last_now   = top_vld[0] ? (!top_vld_up[0] && !rec_vld[0]) : !rec_vld_up[0];
   assign load       = (state_ff == p12tk_pkg::ST_DRAIN) && any_left
                       && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      top_ctl.full = top_vld[TOP_COUNT-1];
      rec_ctl.full = rec_vld[RECENT_COUNT-1];
      top_ctl.cmd  = p12tk_pkg::CMD_HOLD;
      rec_ctl.cmd  = p12tk_pkg::CMD_HOLD;
      if (push_en) begin
         top_ctl.cmd = p12tk_pkg::CMD_PUSH;
         rec_ctl.cmd = p12tk_pkg::CMD_PUSH;
      end else if (load) begin
         if (top_vld[0]) begin
            top_ctl.cmd = p12tk_pkg::CMD_POP;
         end else begin
            rec_ctl.cmd = p12tk_pkg::CMD_POP;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         p12tk_pkg::ST_IDLE: begin
            if (req_xfer && req_tuser == p12tk_pkg::OP_REPORT) begin
               state_in = p12tk_pkg::ST_DRAIN;
            end
         end
         p12tk_pkg::ST_DRAIN: begin
            if (!any_left) begin
               state_in = p12tk_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = p12tk_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= p12tk_pkg::ST_IDLE;
         phase_ff      <= p12tk_pkg::PH_FIRST;
         held_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         held_ff       <= held_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_value_ff   <= top_vld[0] ? top_val[0] : rec_val[0];
         rsp_section_ff <= !top_vld[0];
         rsp_last_ff    <= last_now;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(16 - p12tk_pkg::VALUE_BITS){1'b0}}, rsp_value_ff};
   assign rsp_tuser  = rsp_section_ff;
   assign rsp_tlast  = rsp_last_ff;

   for (genvar i = 0; i < TOP_COUNT; i++) begin : g_top
      logic                 lo_le;
      p12tk_pkg::value_type lo_value;
      logic                 lo_valid;
      logic                 hi_le;
      p12tk_pkg::value_type hi_value;
      logic                 hi_valid;

      if (i == 0) begin : g_lo_end
         assign lo_le    = 1'b1;
         assign lo_value = '0;
         assign lo_valid = 1'b0;
      end else begin : g_lo
         assign lo_le    = top_le[i-1];
         assign lo_value = top_val[i-1];
         assign lo_valid = top_vld[i-1];
      end

      if (i == TOP_COUNT - 1) begin : g_hi_end
         assign hi_le    = 1'b0;
         assign hi_value = '0;
         assign hi_valid = 1'b0;
      end else begin : g_hi
         assign hi_le    = top_le[i+1];
         assign hi_value = top_val[i+1];
         assign hi_valid = top_vld[i+1];
      end

      p12tk_top_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (top_ctl),
         .new_value (push_value),
         .lo_le     (lo_le),
         .lo_value  (lo_value),
         .lo_valid  (lo_valid),
         .hi_le     (hi_le),
         .hi_value  (hi_value),
         .hi_valid  (hi_valid),
         .value     (top_val[i]),
         .valid     (top_vld[i]),
         .le        (top_le[i])
      );
   end

   for (genvar i = 0; i < RECENT_COUNT; i++) begin : g_rec
      logic                 lo_valid;
      p12tk_pkg::value_type hi_value;
      logic                 hi_valid;

      if (i == 0) begin : g_lo_end
         assign lo_valid = 1'b1;
      end else begin : g_lo
         assign lo_valid = rec_vld[i-1];
      end

      if (i == RECENT_COUNT - 1) begin : g_hi_end
         assign hi_value = '0;
         assign hi_valid = 1'b0;
      end else begin : g_hi
         assign hi_value = rec_val[i+1];
         assign hi_valid = rec_vld[i+1];
      end

      p12tk_rec_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (rec_ctl),
         .new_value (push_value),
         .is_last   (i == RECENT_COUNT - 1),
         .lo_valid  (lo_valid),
         .hi_value  (hi_value),
         .hi_valid  (hi_valid),
         .value     (rec_val[i]),
         .valid     (rec_vld[i])
      );
   end

endmodule
